FILE: hw/rtl/beep_pattern_sequencer_unit_macros.svh
// Assertion macros for the beep pattern sequencer checker.
// No dependencies; included by files that carry assertions.
`ifndef BEEP_PATTERN_SEQUENCER_UNIT_MACROS_SVH
`define BEEP_PATTERN_SEQUENCER_UNIT_MACROS_SVH

// Clocked on clk_i, quiet while rst_ni is low.
`define BPS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("bps assertion failed");

// Same, with antecedent and consequent written apart (overlapping).
`define BPS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bps implication failed");

// Next-cycle implication.
`define BPS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bps next-cycle implication failed");

`endif

FILE: hw/rtl/bps_pkg.sv
// Shared types and constants for the beep pattern sequencer.
// No dependencies.
package bps_pkg;

  localparam int unsigned SLOTS_DEF    = 6;
  localparam int unsigned DUR_BITS_DEF = 11;
  localparam int unsigned CHANNELS_DEF = 2;

  localparam int unsigned CFG_IDX_W = 3;

  // Reset contents of the pattern and duration registers
  localparam logic [63:0] PAT_CH0_RST  = 64'd10329;
  localparam logic [63:0] PAT_CH1_RST  = 64'd1;
  localparam logic [63:0] DOT_CH0_MS   = 64'd110;
  localparam logic [63:0] DASH_CH0_MS  = 64'd1000;
  localparam logic [63:0] SPACE_CH0_MS = 64'd130;
  localparam logic [63:0] LONG_CH0_MS  = 64'd200;
  localparam logic [63:0] DOT_CH1_MS   = 64'd50;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MENU_SOUND    = 3'd0,
    CFG_PATTERN_CH0   = 3'd1,
    CFG_PATTERN_CH1   = 3'd2,
    CFG_DURATIONS_CH0 = 3'd3,
    CFG_DURATIONS_CH1 = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    SYM_END        = 3'd0,
    SYM_DOT        = 3'd1,
    SYM_DASH       = 3'd2,
    SYM_SPACE      = 3'd3,
    SYM_LONG_SPACE = 3'd4
  } sym_e;

  // One channel's write to the shared sounder during a tick
  typedef struct packed {
    logic we;
    logic val;
  } snd_wr_t;

endpackage

FILE: hw/rtl/beep_pattern_sequencer_unit.sv
// Beep pattern sequencer: several buzzer pattern channels sharing one sounder.
// The result beat for an item is offered the cycle after it is taken.
// Throughput: one item per cycle while the receiver takes results, set by the single register stage of channel state.
// The state registers are the result register; a new beat is taken as the old one leaves.
// Reset (rst_ni low, asynchronous): channels idle and disarmed, sounder off,
// registers back to their default patterns and durations, no result pending.
module beep_pattern_sequencer_unit #(
  parameter int unsigned SLOTS    = bps_pkg::SLOTS_DEF,
  parameter int unsigned DUR_BITS = bps_pkg::DUR_BITS_DEF,
  parameter int unsigned CHANNELS = bps_pkg::CHANNELS_DEF,
  localparam int unsigned CFG_DATA_W = (4 * DUR_BITS > 3 * SLOTS) ? 4 * DUR_BITS : 3 * SLOTS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [bps_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DATA_W-1:0]         cfg_data_i,
  // input items
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          opcode_i,
  input  logic                          channel_i,
  input  logic                          override_i,
  // result items
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          sounder_on_o,
  output logic                          busy_ch0_o,
  output logic                          busy_ch1_o
);

  logic                  menu_sound;
  logic [3*SLOTS-1:0]    pattern   [CHANNELS];
  logic [4*DUR_BITS-1:0] durations [CHANNELS];

  logic                  in_beat, tick, trig;
  logic                  out_valid_q, out_valid_d;
  logic                  sounder_q, sounder_d;
  logic [CHANNELS-1:0]   busy;
  logic [CHANNELS:0]     busy_ext;
  bps_pkg::snd_wr_t      snd_wr [CHANNELS];

  // Registers take every write; the user must change the map only while the block is idle (not enforced here).
  assign cfg_ready_o = 1'b1;

  bps_cfg_regs #(
    .SLOTS      (SLOTS),
    .DUR_BITS   (DUR_BITS),
    .CHANNELS   (CHANNELS),
    .CFG_DATA_W (CFG_DATA_W)
  ) u_cfg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .menu_sound_o (menu_sound),
    .pattern_o    (pattern),
    .durations_o  (durations)
  );

  // A beat is taken whenever the result slot is empty or being emptied.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_beat    = in_valid_i && in_ready_o;
  assign tick       = in_beat && !opcode_i;
  // trigger needs menu sound or override; the channel itself ignores it while playing
  assign trig       = in_beat && opcode_i && (menu_sound || override_i);

  for (genvar c = 0; c < CHANNELS; c++) begin : g_ch
    // the channel field is one bit wide, so channels from two upwards are never addressed
    logic hit;
    assign hit = (c < 2) && (channel_i == 1'(c));

    bps_channel #(
      .SLOTS    (SLOTS),
      .DUR_BITS (DUR_BITS)
    ) u_channel (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .tick_i      (tick),
      .trig_i      (trig && hit),
      .pattern_i   (pattern[c]),
      .durations_i (durations[c]),
      .busy_o      (busy[c]),
      .snd_o       (snd_wr[c])
    );
  end

  // Channels act in index order on the shared sounder: the highest writer wins.
  always_comb begin
    sounder_d = sounder_q;
    if (tick) begin
      for (int c = 0; c < CHANNELS; c++) begin
        if (snd_wr[c].we) begin
          sounder_d = snd_wr[c].val;
        end
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (in_beat) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sounder_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      sounder_q   <= sounder_d;
      out_valid_q <= out_valid_d;
    end
  end

  // State only moves on a taken beat, so it holds steady while a result waits.
  assign busy_ext     = {1'b0, busy};
  assign out_valid_o  = out_valid_q;
  assign sounder_on_o = sounder_q;
  assign busy_ch0_o   = busy_ext[0];
  assign busy_ch1_o   = busy_ext[1];

endmodule

FILE: hw/rtl/bps_cfg_regs.sv
// Configuration register file: menu-sound flag, patterns and durations.
// Depends on bps_pkg.
module bps_cfg_regs #(
  parameter int unsigned SLOTS      = bps_pkg::SLOTS_DEF,
  parameter int unsigned DUR_BITS   = bps_pkg::DUR_BITS_DEF,
  parameter int unsigned CHANNELS   = bps_pkg::CHANNELS_DEF,
  parameter int unsigned CFG_DATA_W = 44
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bps_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0]          cfg_data_i,
  output logic                           menu_sound_o,
  output logic [3*SLOTS-1:0]             pattern_o   [CHANNELS],
  output logic [4*DUR_BITS-1:0]          durations_o [CHANNELS]
);

  localparam int unsigned PAT_W = 3 * SLOTS;
  localparam int unsigned DUR_W = 4 * DUR_BITS;

  localparam logic [63:0] DUR_CH0_RST = bps_pkg::DOT_CH0_MS
                                      | (bps_pkg::DASH_CH0_MS << DUR_BITS)
                                      | (bps_pkg::SPACE_CH0_MS << (2 * DUR_BITS))
                                      | (bps_pkg::LONG_CH0_MS << (3 * DUR_BITS));

  logic menu_sound_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      menu_sound_q <= 1'b0;
    end else if (cfg_we_i && (cfg_index_i == bps_pkg::CFG_MENU_SOUND)) begin
      menu_sound_q <= cfg_data_i[0];
    end
  end

  assign menu_sound_o = menu_sound_q;

  for (genvar c = 0; c < CHANNELS; c++) begin : g_ch
    // only the first two channels have registers in the map
    localparam bit HasRegs = (c < 2);
    localparam bps_pkg::cfg_idx_e PatIdx =
        (c == 0) ? bps_pkg::CFG_PATTERN_CH0 : bps_pkg::CFG_PATTERN_CH1;
    localparam bps_pkg::cfg_idx_e DurIdx =
        (c == 0) ? bps_pkg::CFG_DURATIONS_CH0 : bps_pkg::CFG_DURATIONS_CH1;
    localparam logic [63:0] PatRst = (c == 0) ? bps_pkg::PAT_CH0_RST :
                                     (c == 1) ? bps_pkg::PAT_CH1_RST : 64'd0;
    localparam logic [63:0] DurRst = (c == 0) ? DUR_CH0_RST :
                                     (c == 1) ? bps_pkg::DOT_CH1_MS : 64'd0;

    logic [PAT_W-1:0] pattern_q;
    logic [DUR_W-1:0] durations_q;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        pattern_q   <= PatRst[PAT_W-1:0];
        durations_q <= DurRst[DUR_W-1:0];
      end else if (cfg_we_i && HasRegs) begin
        if (cfg_index_i == PatIdx) begin
          pattern_q <= cfg_data_i[PAT_W-1:0];
        end
        if (cfg_index_i == DurIdx) begin
          durations_q <= cfg_data_i[DUR_W-1:0];
        end
      end
    end

    assign pattern_o[c]   = pattern_q;
    assign durations_o[c] = durations_q;
  end

endmodule

FILE: hw/rtl/bps_channel.sv
// One pattern channel: arm/play state, elapsed counter and slot stepping.
// Depends on bps_pkg.
module bps_channel #(
  parameter int unsigned SLOTS    = bps_pkg::SLOTS_DEF,
  parameter int unsigned DUR_BITS = bps_pkg::DUR_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   tick_i,
  input  logic                   trig_i,
  input  logic [3*SLOTS-1:0]     pattern_i,
  input  logic [4*DUR_BITS-1:0]  durations_i,
  output logic                   busy_o,
  output bps_pkg::snd_wr_t       snd_o
);

  localparam int unsigned SLOT_W = $clog2(SLOTS);

  logic                armed_q, armed_d;
  logic                playing_q, playing_d;
  logic [SLOT_W-1:0]   slot_q, slot_d;
  logic [DUR_BITS-1:0] elapsed_q, elapsed_d;

  logic                fresh, active, done, stop;
  logic [DUR_BITS-1:0] elapsed_cnt, sym_dur;
  logic [SLOT_W:0]     slot_nxt;
  logic [2:0]          sym, sym_nxt;

  assign sym = ({1'b0, slot_q} < (SLOT_W + 1)'(SLOTS)) ? pattern_i[3 * slot_q +: 3]
                                                        : bps_pkg::SYM_END;

  always_comb begin
    unique case (sym)
      bps_pkg::SYM_DOT:        sym_dur = durations_i[0 +: DUR_BITS];
      bps_pkg::SYM_DASH:       sym_dur = durations_i[DUR_BITS +: DUR_BITS];
      bps_pkg::SYM_SPACE:      sym_dur = durations_i[2 * DUR_BITS +: DUR_BITS];
      bps_pkg::SYM_LONG_SPACE: sym_dur = durations_i[3 * DUR_BITS +: DUR_BITS];
      default:                 sym_dur = '0;   // end and unused codes pass at once
    endcase
  end

  assign fresh  = armed_q && !playing_q;
  assign active = playing_q || fresh;

  always_comb begin
    if (fresh) begin
      elapsed_cnt = '0;
    end else if (playing_q && (elapsed_q != '1)) begin
      elapsed_cnt = elapsed_q + 1'b1;
    end else begin
      elapsed_cnt = elapsed_q;
    end
  end

  assign done     = active && (elapsed_cnt >= sym_dur);
  assign slot_nxt = {1'b0, slot_q} + 1'b1;
  assign stop     = (sym == bps_pkg::SYM_END) || (slot_nxt >= (SLOT_W + 1)'(SLOTS));
  assign sym_nxt  = stop ? bps_pkg::SYM_END : pattern_i[3 * slot_nxt +: 3];

  always_comb begin
    armed_d   = armed_q;
    playing_d = playing_q;
    slot_d    = slot_q;
    elapsed_d = elapsed_q;
    snd_o     = '0;
    if (trig_i && !playing_q) begin
      armed_d = 1'b1;
    end
    if (tick_i && active) begin
      armed_d   = 1'b0;
      playing_d = 1'b1;
      elapsed_d = elapsed_cnt;
      if (fresh) begin
        snd_o = '{we: 1'b1, val: 1'b1};
      end
      if (done) begin
        elapsed_d = '0;
        snd_o.we  = 1'b1;
        if (stop) begin
          slot_d    = '0;
          playing_d = 1'b0;
          snd_o.val = 1'b0;
        end else begin
          slot_d    = slot_nxt[SLOT_W-1:0];
          snd_o.val = (sym_nxt == bps_pkg::SYM_DOT) || (sym_nxt == bps_pkg::SYM_DASH);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q   <= 1'b0;
      playing_q <= 1'b0;
      slot_q    <= '0;
      elapsed_q <= '0;
    end else begin
      armed_q   <= armed_d;
      playing_q <= playing_d;
      slot_q    <= slot_d;
      elapsed_q <= elapsed_d;
    end
  end

  assign busy_o = playing_q;

endmodule

FILE: hw/rtl/bps_checker.sv
// Port-level checks for beep_pattern_sequencer_unit, attached by bind.
// Depends on beep_pattern_sequencer_unit_macros.svh.
`include "beep_pattern_sequencer_unit_macros.svh"

module bps_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic opcode_i,
  input logic out_valid_o,
  input logic out_ready_i,
  input logic sounder_on_o,
  input logic busy_ch0_o,
  input logic busy_ch1_o
);

  logic in_beat;
  logic tick_beat;

  assign in_beat   = in_valid_i && in_ready_o;
  assign tick_beat = in_beat && !opcode_i;

  `BPS_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o)
  `BPS_ASSERT_NXT(a_beat_gives_result, in_beat, out_valid_o)
  `BPS_ASSERT_IMP(a_sounder_needs_player, sounder_on_o, busy_ch0_o || busy_ch1_o)
  `BPS_ASSERT_NXT(a_idle_holds, !in_beat, $stable({sounder_on_o, busy_ch0_o, busy_ch1_o}))
  `BPS_ASSERT_IMP(a_start_on_tick, $rose(busy_ch0_o) || $rose(busy_ch1_o), $past(tick_beat))

endmodule

bind beep_pattern_sequencer_unit bps_checker u_bps_checker (.*);

FILE: tb/sv/beep_pattern_sequencer_unit_tb.sv
// Self-checking testbench for beep_pattern_sequencer_unit: directed table, then random phases.
// Depends on bps_pkg and the beep_pattern_sequencer_unit RTL only.
module beep_pattern_sequencer_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bps_pkg::*;

  localparam int unsigned SLOTS    = SLOTS_DEF;
  localparam int unsigned DUR_BITS = DUR_BITS_DEF;
  localparam int unsigned CHANNELS = CHANNELS_DEF;
  localparam int unsigned PAT_W    = 3 * SLOTS;
  localparam int unsigned DUR_W    = 4 * DUR_BITS;
  localparam int unsigned CFG_W    = (DUR_W > PAT_W) ? DUR_W : PAT_W;

  // Item opcodes
  localparam logic OP_TICK    = 1'b0;
  localparam logic OP_TRIGGER = 1'b1;

  localparam int RANDOM_ITEMS = 1150;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_AT_BEAT = 500;   // result beat count that starts the long receiver hold
  localparam int HOLD_CYCLES  = 300;
  localparam int MAX_REPORTS  = 10;

  // One result beat, in port order
  typedef struct packed {
    logic sounder_on;
    logic busy_ch0;
    logic busy_ch1;
  } beep_beat_t;

  // One row of the directed table: either a register write or an input item
  typedef struct packed {
    bit                 is_cfg;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_W-1:0]   data;
    logic               op;
    logic               ch;
    logic               ovr;
    bit                 typed;  // expected beat written in the row itself
    beep_beat_t         want;
  } dir_row_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_W-1:0]     cfg_data_i;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic                 opcode_i;
  logic                 channel_i;
  logic                 override_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic                 sounder_on_o;
  logic                 busy_ch0_o;
  logic                 busy_ch1_o;

  beep_pattern_sequencer_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .opcode_i     (opcode_i),
    .channel_i    (channel_i),
    .override_i   (override_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .sounder_on_o (sounder_on_o),
    .busy_ch0_o   (busy_ch0_o),
    .busy_ch1_o   (busy_ch1_o)
  );

  // ---------------------------------------------------------------------------
  // Player model: own copy of registers and channel state
  // ---------------------------------------------------------------------------
  logic                menu_sound;
  logic [PAT_W-1:0]    ch_pattern   [CHANNELS];
  logic [DUR_W-1:0]    ch_durations [CHANNELS];
  logic                tone_level;
  logic                ch_armed     [CHANNELS];
  logic                ch_playing   [CHANNELS];
  logic [2:0]          ch_slot      [CHANNELS];
  logic [DUR_BITS-1:0] ch_elapsed   [CHANNELS];

  beep_beat_t pending_beats[$];   // expected result beats, oldest first
  int         fail_count;
  int         beats_seen;
  int         cycle_count;
  int         burst_left;

  task automatic player_reset();
    menu_sound = 1'b0;
    tone_level = 1'b0;
    for (int c = 0; c < CHANNELS; c++) begin
      ch_armed[c]   = 1'b0;
      ch_playing[c] = 1'b0;
      ch_slot[c]    = '0;
      ch_elapsed[c] = '0;
    end
    ch_pattern[0]   = PAT_W'(PAT_CH0_RST);
    ch_pattern[1]   = PAT_W'(PAT_CH1_RST);
    ch_durations[0] = {LONG_CH0_MS[DUR_BITS-1:0], SPACE_CH0_MS[DUR_BITS-1:0],
                       DASH_CH0_MS[DUR_BITS-1:0], DOT_CH0_MS[DUR_BITS-1:0]};
    ch_durations[1] = DUR_W'(DOT_CH1_MS);
  endtask

  task automatic apply_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    case (idx)
      CFG_MENU_SOUND:    menu_sound      = data[0];
      CFG_PATTERN_CH0:   ch_pattern[0]   = data[PAT_W-1:0];
      CFG_PATTERN_CH1:   ch_pattern[1]   = data[PAT_W-1:0];
      CFG_DURATIONS_CH0: ch_durations[0] = data[DUR_W-1:0];
      CFG_DURATIONS_CH1: ch_durations[1] = data[DUR_W-1:0];
      default: ;  // indexes past the list are dropped
    endcase
  endtask

  function automatic logic [2:0] symbol_of(input int c, input int slot);
    if (slot >= SLOTS) return SYM_END;
    return ch_pattern[c][3*slot +: 3];
  endfunction

  // Unknown codes have no duration and pass on the same tick
  function automatic logic [DUR_BITS-1:0] symbol_ms(input int c, input logic [2:0] sym);
    if (sym < SYM_DOT || sym > SYM_LONG_SPACE) return '0;
    return ch_durations[c][DUR_BITS*(int'(sym)-1) +: DUR_BITS];
  endfunction

  task automatic step_channel(input int c);
    logic [2:0] sym;
    logic [2:0] nsym;
    bit         fresh;
    int         nxt;
    sym   = symbol_of(c, int'(ch_slot[c]));
    fresh = 1'b0;
    if (ch_armed[c] && !ch_playing[c]) begin
      tone_level    = 1'b1;
      ch_playing[c] = 1'b1;
      ch_armed[c]   = 1'b0;
      ch_elapsed[c] = '0;
      fresh         = 1'b1;
    end
    if (!ch_playing[c]) return;
    // saturating ms count; a channel started on this tick stays at zero
    if (!fresh && ch_elapsed[c] != '1) ch_elapsed[c] = ch_elapsed[c] + 1'b1;
    if (ch_elapsed[c] < symbol_ms(c, sym)) return;
    tone_level    = 1'b0;
    ch_elapsed[c] = '0;
    nxt           = int'(ch_slot[c]) + 1;
    if (sym == SYM_END || nxt >= SLOTS) begin
      ch_slot[c]    = '0;
      ch_playing[c] = 1'b0;
      return;
    end
    ch_slot[c] = 3'(nxt);
    nsym       = symbol_of(c, nxt);
    tone_level = (nsym == SYM_DOT) || (nsym == SYM_DASH);
  endtask

  task automatic predict_beat(input logic op, input logic ch, input logic ovr,
                              output beep_beat_t beat);
    if (op == OP_TRIGGER) begin
      if ((menu_sound || ovr) && !ch_playing[ch]) ch_armed[ch] = 1'b1;
    end else begin
      for (int c = 0; c < CHANNELS; c++) step_channel(c);
    end
    beat = '{tone_level, ch_playing[0], ch_playing[1]};
  endtask

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("%s", msg);
  endtask

  // ---------------------------------------------------------------------------
  // Clock, reset and cycle limit
  // ---------------------------------------------------------------------------
  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stall stretches plus one long hold so the input backs up
  // ---------------------------------------------------------------------------
  int rx_mode;
  int rx_stretch;
  int hold_left;
  bit hold_done;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (!hold_done && beats_seen >= HOLD_AT_BEAT) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        if (rx_stretch == 0) begin
          rx_mode    = $urandom_range(0, 2);
          rx_stretch = $urandom_range(10, 80);
        end
        rx_stretch--;
        case (rx_mode)
          0:       out_ready_i <= 1'b1;
          1:       out_ready_i <= 1'($urandom_range(0, 1));
          default: out_ready_i <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: every beat against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    beep_beat_t got;
    beep_beat_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{sounder_on_o, busy_ch0_o, busy_ch1_o};
      beats_seen++;
      if (pending_beats.size() == 0) begin
        note_failure($sformatf("unexpected result beat: sounder %b busy %b%b",
                               got.sounder_on, got.busy_ch1, got.busy_ch0));
      end else begin
        want = pending_beats.pop_front();
        if (got.sounder_on !== want.sounder_on || got.busy_ch0 !== want.busy_ch0 ||
            got.busy_ch1 !== want.busy_ch1)
          note_failure($sformatf(
            "beat %0d mismatch: sounder exp %b got %b, ch0 exp %b got %b, ch1 exp %b got %b",
            beats_seen, want.sounder_on, got.sounder_on, want.busy_ch0, got.busy_ch0,
            want.busy_ch1, got.busy_ch1));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------
  // Waits until every expected beat is back; input valid drops here.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk_i);
  endtask

  // Config valid is left high so back-to-back writes need no second assignment.
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    settle();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    apply_register(idx, data);
  endtask

  // Items go out in bursts of random length with random gaps in between.
  task automatic send_item(input logic op, input logic ch, input logic ovr,
                           input bit typed, input beep_beat_t want);
    int         gap;
    beep_beat_t calc;
    if (cfg_valid_i) cfg_valid_i <= 1'b0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    opcode_i   <= op;
    channel_i  <= ch;
    override_i <= ovr;
    predict_beat(op, ch, ovr, calc);
    pending_beats.push_back(typed ? want : calc);
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  function automatic dir_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [CFG_W-1:0] data);
    dir_row_t r;
    r        = '0;
    r.is_cfg = 1'b1;
    r.idx    = idx;
    r.data   = data;
    return r;
  endfunction

  function automatic dir_row_t item_row(input logic op, input logic ch, input logic ovr);
    dir_row_t r;
    r     = '0;
    r.op  = op;
    r.ch  = ch;
    r.ovr = ovr;
    return r;
  endfunction

  function automatic dir_row_t typed_row(input logic op, input logic ch, input logic ovr,
                                         input beep_beat_t want);
    dir_row_t r;
    r       = item_row(op, ch, ovr);
    r.typed = 1'b1;
    r.want  = want;
    return r;
  endfunction

  function automatic logic [CFG_W-1:0] rand_pattern();
    return CFG_W'($urandom_range(0, (1 << PAT_W) - 1));
  endfunction

  // Mostly short symbols so patterns run through within a phase
  function automatic logic [CFG_W-1:0] rand_durations();
    logic [CFG_W-1:0] d;
    d = '0;
    for (int f = 0; f < 4; f++)
      d[f*DUR_BITS +: DUR_BITS] = ($urandom_range(0, 7) == 0) ?
        DUR_BITS'($urandom_range(0, 60)) : DUR_BITS'($urandom_range(0, 6));
    return d;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    dir_row_t dir_rows[$];
    int       n_items;
    int       phase;
    int       random_items;
    logic     op;

    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    opcode_i    = 1'b0;
    channel_i   = 1'b0;
    override_i  = 1'b0;
    out_ready_i = 1'b0;
    fail_count  = 0;
    beats_seen  = 0;
    cycle_count = 0;
    burst_left  = 0;
    rx_mode     = 0;
    rx_stretch  = 0;
    hold_left   = 0;
    hold_done   = 1'b0;
    player_reset();

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    dir_rows = '{
      // reset defaults: menu sound off, channel 1 plays a single 50 ms dot
      typed_row(OP_TICK,    1'b0, 1'b0, '{1'b0, 1'b0, 1'b0}),
      typed_row(OP_TRIGGER, 1'b0, 1'b0, '{1'b0, 1'b0, 1'b0}),  // no menu sound, no override
      typed_row(OP_TRIGGER, 1'b1, 1'b1, '{1'b0, 1'b0, 1'b0}),  // arms only
      typed_row(OP_TICK,    1'b0, 1'b0, '{1'b1, 1'b0, 1'b1}),  // channel 1 starts
      typed_row(OP_TRIGGER, 1'b1, 1'b1, '{1'b1, 1'b0, 1'b1}),  // retrigger while playing
      item_row(OP_TRIGGER, 1'b0, 1'b1),
      item_row(OP_TICK,    1'b0, 1'b0),
      // all-ones pattern: unknown symbols, running past the last slot
      cfg_row(CFG_MENU_SOUND,    CFG_W'(1)),
      cfg_row(CFG_PATTERN_CH0,   CFG_W'({PAT_W{1'b1}})),
      cfg_row(CFG_DURATIONS_CH0, {CFG_W{1'b1}}),
      cfg_row(CFG_PATTERN_CH1,   '0),
      cfg_row(CFG_DURATIONS_CH1, '0),
      item_row(OP_TICK,    1'b0, 1'b0),
      item_row(OP_TICK,    1'b0, 1'b0),
      item_row(OP_TRIGGER, 1'b0, 1'b0),
      item_row(OP_TICK,    1'b1, 1'b1),
      item_row(OP_TRIGGER, 1'b1, 1'b0),
      item_row(OP_TICK,    1'b0, 1'b0),
      item_row(OP_TICK,    1'b0, 1'b0),
      // every symbol kind on channel 1, short durations, no end symbol
      cfg_row(CFG_PATTERN_CH1, CFG_W'({SYM_DASH, SYM_DOT, SYM_LONG_SPACE,
                                       SYM_DASH, SYM_SPACE, SYM_DOT})),
      cfg_row(CFG_DURATIONS_CH1, CFG_W'({11'd1, 11'd2, 11'd1, 11'd2})),
      item_row(OP_TRIGGER, 1'b1, 1'b1)
    };
    repeat (10) dir_rows.push_back(item_row(OP_TICK, 1'b0, 1'b0));

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg)
        cfg_write(dir_rows[i].idx, dir_rows[i].data);
      else
        send_item(dir_rows[i].op, dir_rows[i].ch, dir_rows[i].ovr,
                  dir_rows[i].typed, dir_rows[i].want);
    end

    // Random phases, each under a fresh register setting
    phase        = 0;
    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      case (phase)
        0: begin
          cfg_write(CFG_MENU_SOUND,    {CFG_W{1'b1}});
          cfg_write(CFG_PATTERN_CH0,   {CFG_W{1'b1}});
          cfg_write(CFG_PATTERN_CH1,   {CFG_W{1'b1}});
          cfg_write(CFG_DURATIONS_CH0, {CFG_W{1'b1}});
          cfg_write(CFG_DURATIONS_CH1, {CFG_W{1'b1}});
          // indexes past the list must leave everything alone
          for (int k = int'(CFG_DURATIONS_CH1) + 1; k < (1 << CFG_IDX_W); k++)
            cfg_write(CFG_IDX_W'(k), '0);
        end
        1: begin
          cfg_write(CFG_MENU_SOUND,    '0);
          cfg_write(CFG_PATTERN_CH0,   '0);
          cfg_write(CFG_PATTERN_CH1,   '0);
          cfg_write(CFG_DURATIONS_CH0, '0);
          cfg_write(CFG_DURATIONS_CH1, '0);
        end
        default: begin
          cfg_write(CFG_MENU_SOUND,    CFG_W'($urandom_range(0, 1)));
          cfg_write(CFG_PATTERN_CH0,   rand_pattern());
          cfg_write(CFG_PATTERN_CH1,   rand_pattern());
          cfg_write(CFG_DURATIONS_CH0, rand_durations());
          cfg_write(CFG_DURATIONS_CH1, rand_durations());
        end
      endcase
      n_items = $urandom_range(60, 140);
      repeat (n_items) begin
        op = ($urandom_range(0, 9) < 3) ? OP_TRIGGER : OP_TICK;
        send_item(op, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b0, '0);
      end
      random_items += n_items;
      phase++;
    end

    settle();
    cfg_valid_i <= 1'b0;
    repeat (4) @(posedge clk_i);
    if (pending_beats.size() != 0) note_failure("expected beats left over at the end");
    if (fail_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
